// ===== rtl/s2lab_pkg.sv =====
// Shared types, constants and the sRGB linearization table for the sRGB to L*a*b* converter.
`timescale 1ns / 1ps

package s2lab_pkg;

    // Field and datapath widths.
    localparam int CODE_W   = 8;
    localparam int WHITE_W  = 17;
    localparam int LIN_W    = 31;   // linear channel value, Q30, 0..2^30
    localparam int WGT_W    = 14;   // matrix weight in 1/10000
    localparam int PROD_W   = WGT_W + LIN_W;
    localparam int NUM_W    = 48;   // ten times the weighted sum, also the ratio width
    localparam int ROOT_W   = 26;   // cube root in Q20
    localparam int ROOT_FRAC = 20;
    localparam int TGT_W    = 3 * ROOT_W - 2 * ROOT_FRAC;
    localparam int SQ_W     = 2 * ROOT_W - ROOT_FRAC;

    // Linear pivot segment: 7787 * r / 1000 plus 16/116 in Q30.
    localparam int LMUL_W   = 37;   // 7787 * r for a ratio below 2^24
    localparam int LQ_W     = 34;   // that product divided by 8
    localparam logic [12:0] LIN_MUL = 13'd7787;
    // Division by 125 is a multiply by ceil(2^41 / 125), split into a high and a low half.
    localparam int RCP_LO_W = 18;
    localparam int RCP_HI_W = 17;
    localparam int RCP_SH   = 41;
    localparam logic [RCP_LO_W-1:0] RCP_LO = 18'd226493;
    localparam logic [RCP_HI_W-1:0] RCP_HI = 17'd67108;
    localparam int LSUM_W   = 37;
    localparam logic [LSUM_W-1:0] PIVOT_OFS = 37'd148102320;
    localparam logic [NUM_W-1:0] PIVOT_LIMIT = 48'd9509057;

    localparam int L_OFS = 16 << ROOT_FRAC;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WHITE_X = 2'd0,
        CFG_WHITE_Y = 2'd1,
        CFG_WHITE_Z = 2'd2
    } t_cfg_idx;

    localparam logic [WHITE_W-1:0] WHITE_X_RST = 17'd95047;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 17'd100000;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 17'd108883;

    // sRGB to XYZ matrix in 1/10000, rows X, Y, Z.
    typedef logic [WGT_W-1:0] t_wgt_mat [3][3];
    localparam t_wgt_mat WEIGHT = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    typedef logic [LIN_W-1:0] t_lin_tab [256];

    // Linear value of one 8-bit code in Q30, following the exact fixed-point recipe.
    function automatic logic [LIN_W-1:0] lin_entry(input longint unsigned code);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned w2;
        longint unsigned w4;
        longint unsigned w5;
        if (code * 100000 <= 1031475) begin
            return LIN_W'(((code << 30) * 5) / 16473);
        end
        t  = ((1000 * code + 14025) << 30) / 269025;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = (64'd1 << 30) + 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            w2  = (mid * mid) >> 30;
            w4  = (w2 * w2) >> 30;
            w5  = (w4 * mid) >> 30;
            if (w5 <= t2) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return LIN_W'((t2 * lo) >> 30);
    endfunction

    function automatic t_lin_tab lin_table();
        t_lin_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = lin_entry(longint'(c));
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = lin_table();

endpackage

// ===== rtl/s2lab_in_if.sv =====
// Pixel request channel carrying one gamma-encoded sRGB pixel.
`timescale 1ns / 1ps

interface s2lab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/s2lab_out_if.sv =====
// Result request channel carrying one L*a*b* pixel.
`timescale 1ns / 1ps

interface s2lab_out_if;
    logic               valid;
    logic               ready;
    logic        [14:0] lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;

    modport source (output valid, output lightness, output green_red, output blue_yellow,
                    input ready);
    modport sink   (input valid, input lightness, input green_red, input blue_yellow,
                    output ready);
endinterface

// ===== rtl/s2lab_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module s2lab_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    // Each stage shifts the dividend left by one and fills the freed bit with a quotient bit.
    logic [NUM_W-1:0] r_sh  [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W-1];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [NUM_W-1:0] w_sh_in;
        logic [DEN_W-1:0] w_rem_in;
        logic [DEN_W:0]   w_part;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;

        if (i == 0) begin : g_first
            assign w_sh_in  = i_num;
            assign w_rem_in = '0;
        end else begin : g_next
            assign w_sh_in  = r_sh[i-1];
            assign w_rem_in = r_rem[i-1];
        end

        assign w_part = {w_rem_in, w_sh_in[NUM_W-1]};
        assign w_ge   = w_part >= {1'b0, i_den};
        assign w_diff = w_part - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[i] <= {w_sh_in[NUM_W-2:0], w_ge};
            end
        end

        if (i < NUM_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= w_ge ? w_diff[DEN_W-1:0] : w_part[DEN_W-1:0];
                end
            end
        end
    end

    assign o_quo = r_sh[NUM_W-1];

endmodule

// ===== rtl/s2lab_cbrt.sv =====
// Pipelined bitwise cube-root search in Q20, two stages per result bit.
`timescale 1ns / 1ps

module s2lab_cbrt
    import s2lab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [TGT_W-1:0]  i_target,
    output logic [ROOT_W-1:0] o_root
);

    logic [ROOT_W-1:0] r_a_mid [ROOT_W];
    logic [ROOT_W-1:0] r_a_lo  [ROOT_W];
    logic [SQ_W-1:0]   r_a_sq  [ROOT_W];
    logic [TGT_W-1:0]  r_a_tgt [ROOT_W];
    logic [ROOT_W-1:0] r_b_lo  [ROOT_W];
    logic [TGT_W-1:0]  r_b_tgt [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [ROOT_W-1:0]        w_lo_in;
        logic [TGT_W-1:0]         w_tgt_in;
        logic [ROOT_W-1:0]        w_mid;
        logic [2*ROOT_W-1:0]      w_sq_full;
        logic [SQ_W+ROOT_W-1:0]   w_cube_full;
        logic [TGT_W-1:0]         w_cube;

        if (k == 0) begin : g_first
            assign w_lo_in  = '0;
            assign w_tgt_in = i_target;
        end else begin : g_next
            assign w_lo_in  = r_b_lo[k-1];
            assign w_tgt_in = r_b_tgt[k-1];
        end

        // Trial value: the bits decided so far plus this step's bit.
        assign w_mid     = w_lo_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
        assign w_sq_full = (2*ROOT_W)'(w_mid) * (2*ROOT_W)'(w_mid);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_mid[k] <= w_mid;
                r_a_lo[k]  <= w_lo_in;
                r_a_sq[k]  <= w_sq_full[2*ROOT_W-1:ROOT_FRAC];
                r_a_tgt[k] <= w_tgt_in;
            end
        end

        assign w_cube_full = (SQ_W+ROOT_W)'(r_a_sq[k]) * (SQ_W+ROOT_W)'(r_a_mid[k]);
        assign w_cube      = w_cube_full[SQ_W+ROOT_W-1:ROOT_FRAC];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_b_lo[k] <= (w_cube <= r_a_tgt[k]) ? r_a_mid[k] : r_a_lo[k];
            end
        end

        if (k < ROOT_W - 1) begin : g_tgt
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_b_tgt[k] <= r_a_tgt[k];
                end
            end
        end
    end

    assign o_root = r_b_lo[ROOT_W-1];

endmodule

// ===== rtl/srgb_to_cielab.sv =====
// Top level of the sRGB to CIE L*a*b* pixel converter.
`timescale 1ns / 1ps

// The converter takes one 8-bit sRGB pixel per clock and returns L*, a* and b* scaled by
// 2^FRAC_BITS, rounded and saturated. Most of the pipeline lies in two units: the 48-stage
// divider that forms each XYZ-over-white ratio, and the cube-root search, which decides
// one of 26 root bits in every pair of stages. Three stages in front do the transfer-curve
// lookup and the matrix, and two at the end form and round L*, a* and b*. The pipeline
// moves as a whole: when the result at the end is not taken, every stage holds, and the
// input stops taking pixels until it moves again. The user must write the reference white
// through the configuration port (index 0 for X, 1 for Y, 2 for Z, in hundred-thousandths)
// only while no pixel is in flight; the block does not enforce it. A white of zero acts as one.
module srgb_to_cielab
    import s2lab_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [WHITE_W-1:0] i_cfg_data,
    s2lab_in_if.sink           i_pix,
    s2lab_out_if.source        o_lab
);

    localparam int OUT_SHIFT = ROOT_FRAC - FRAC_BITS;
    localparam int CBRT_LAT  = 2 * ROOT_W;
    localparam int LIN_DLY   = CBRT_LAT - 2;
    localparam int LAT       = 3 + NUM_W + CBRT_LAT + 2;
    localparam int LFULL_W   = LQ_W + RCP_LO_W + RCP_HI_W;
    localparam logic signed [39:0] HALF = 40'sd1 <<< (OUT_SHIFT - 1);

    // Reference white registers.
    logic [WHITE_W-1:0] r_white [3];
    logic [WHITE_W-1:0] w_den   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white[0] <= WHITE_X_RST;
            r_white[1] <= WHITE_Y_RST;
            r_white[2] <= WHITE_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WHITE_X: r_white[0] <= i_cfg_data;
                CFG_WHITE_Y: r_white[1] <= i_cfg_data;
                CFG_WHITE_Z: r_white[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together; a valid bit follows each pixel.
    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv       = !r_vld[LAT-1] || o_lab.ready;
    assign i_pix.ready = w_adv;
    assign o_lab.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_pix.valid};
        end
    end

    // Stage 1: transfer curve from the constant table.
    logic [LIN_W-1:0] r_lin [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lin[0] <= LIN_TAB[i_pix.red];
            r_lin[1] <= LIN_TAB[i_pix.green];
            r_lin[2] <= LIN_TAB[i_pix.blue];
        end
    end

    logic [ROOT_W-1:0] w_piv [3];

    for (genvar row = 0; row < 3; row++) begin : g_row
        logic [PROD_W-1:0]        r_prod [3];
        logic [PROD_W+1:0]        w_sum;
        logic [NUM_W-1:0]         r_num;
        logic [NUM_W-1:0]         w_ratio;
        logic [ROOT_W-1:0]        w_root;
        logic [LMUL_W-1:0]        r_lmul;
        logic [LQ_W+RCP_LO_W-1:0] r_lp_lo;
        logic [LQ_W+RCP_HI_W-1:0] r_lp_hi;
        logic [LFULL_W-1:0]       w_lfull;
        logic [LSUM_W-1:0]        w_lsum;
        logic [ROOT_W-1:0]        r_lin_d [LIN_DLY];
        logic [CBRT_LAT-1:0]      r_cube_d;

        // Stage 2: one row of the matrix, a multiplier per weight.
        for (genvar col = 0; col < 3; col++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_prod[col] <= PROD_W'(WEIGHT[row][col]) * PROD_W'(r_lin[col]);
                end
            end
        end

        // Stage 3: row sum times ten, ready for the divider.
        assign w_sum = (PROD_W+2)'(r_prod[0]) + (PROD_W+2)'(r_prod[1])
                     + (PROD_W+2)'(r_prod[2]);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_num <= (NUM_W'(w_sum) << 3) + (NUM_W'(w_sum) << 1);
            end
        end

        assign w_den[row] = (r_white[row] == '0) ? WHITE_W'(1) : r_white[row];

        s2lab_div #(
            .NUM_W (NUM_W),
            .DEN_W (WHITE_W)
        ) u_ratio (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_num),
            .i_den (w_den[row]),
            .o_quo (w_ratio)
        );

        // Cube-root branch of the pivot.
        s2lab_cbrt u_cbrt (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_target (w_ratio[NUM_W-1:NUM_W-TGT_W]),
            .o_root   (w_root)
        );

        // Linear branch, only meaningful when the ratio is at or below the limit,
        // where it fits in 24 bits. The division by 1000 is a shift by three followed
        // by a reciprocal multiply for 125, exact for every 34-bit dividend; the product
        // by 7787, the reciprocal products and the shifted sum are registered in turn.
        assign w_lfull = (LFULL_W'(r_lp_hi) << RCP_LO_W) + LFULL_W'(r_lp_lo);
        assign w_lsum  = LSUM_W'(w_lfull >> RCP_SH) + PIVOT_OFS;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_lmul  <= LMUL_W'(LIN_MUL) * LMUL_W'(w_ratio[23:0]);
                r_lp_lo <= (LQ_W+RCP_LO_W)'(r_lmul[LMUL_W-1:3]) * (LQ_W+RCP_LO_W)'(RCP_LO);
                r_lp_hi <= (LQ_W+RCP_HI_W)'(r_lmul[LMUL_W-1:3]) * (LQ_W+RCP_HI_W)'(RCP_HI);
            end
        end

        // Delay lines that line the linear branch and the branch choice up with the root.
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cube_d <= {r_cube_d[CBRT_LAT-2:0], (w_ratio > PIVOT_LIMIT)};
                r_lin_d[0] <= w_lsum[ROOT_W+9:10];
                for (int i = 1; i < LIN_DLY; i++) begin
                    r_lin_d[i] <= r_lin_d[i-1];
                end
            end
        end

        assign w_piv[row] = r_cube_d[CBRT_LAT-1] ? w_root : r_lin_d[LIN_DLY-1];
    end

    // Output stage 1: form L, a and b in Q20.
    logic signed [39:0] w_fx;
    logic signed [39:0] w_fy;
    logic signed [39:0] w_fz;
    logic signed [39:0] r_l;
    logic signed [39:0] r_a;
    logic signed [39:0] r_b;

    assign w_fx = $signed({14'd0, w_piv[0]});
    assign w_fy = $signed({14'd0, w_piv[1]});
    assign w_fz = $signed({14'd0, w_piv[2]});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l <= 40'sd116 * w_fy - 40'(L_OFS);
            r_a <= 40'sd500 * (w_fx - w_fy);
            r_b <= 40'sd200 * (w_fy - w_fz);
        end
    end

    // Output stage 2: round to nearest with ties upward, which is an arithmetic shift of
    // the value plus one half, then saturate.
    logic signed [39:0] w_lr;
    logic signed [39:0] w_ar;
    logic signed [39:0] w_br;
    logic        [14:0] r_lo;
    logic signed [15:0] r_ao;
    logic signed [15:0] r_bo;

    assign w_lr = (r_l + HALF) >>> OUT_SHIFT;
    assign w_ar = (r_a + HALF) >>> OUT_SHIFT;
    assign w_br = (r_b + HALF) >>> OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_lr < 0) begin
                r_lo <= '0;
            end else if (w_lr > 40'sd32767) begin
                r_lo <= 15'h7FFF;
            end else begin
                r_lo <= w_lr[14:0];
            end

            if (w_ar < -40'sd32768) begin
                r_ao <= 16'sh8000;
            end else if (w_ar > 40'sd32767) begin
                r_ao <= 16'sh7FFF;
            end else begin
                r_ao <= w_ar[15:0];
            end

            if (w_br < -40'sd32768) begin
                r_bo <= 16'sh8000;
            end else if (w_br > 40'sd32767) begin
                r_bo <= 16'sh7FFF;
            end else begin
                r_bo <= w_br[15:0];
            end
        end
    end

    assign o_lab.lightness   = r_lo;
    assign o_lab.green_red   = r_ao;
    assign o_lab.blue_yellow = r_bo;

`ifndef SYNTHESIS
    // A held pipeline must not gain or lose pixels.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits changed while the pipeline was held");

    // Every taken request enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && w_adv) |=> r_vld[0])
        else $error("accepted pixel missing from the first stage");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the sRGB to CIE L*a*b* pixel converter.
`timescale 1ns / 1ps

module tb
    import s2lab_pkg::*;
;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic        [14:0] lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } t_lab;

    // Register index that maps to no register; the block must ignore writes to it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // Cycles that cover the pipeline depth once the last result has come out.
    localparam int PIPE_SETTLE = 120;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [WHITE_W-1:0] i_cfg_data;

    s2lab_in_if  pix_ch ();
    s2lab_out_if lab_ch ();

    srgb_to_cielab dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch.sink),
        .o_lab      (lab_ch.source)
    );

    // The testbench's own copy of the reference white.
    longint unsigned white_xyz [3];
    // Our own table of linearized channel values, Q30.
    longint unsigned lin_q30 [256];

    t_pixel pending_pix [$];
    t_lab   expected_lab [$];

    int mismatches   = 0;
    int pix_taken    = 0;
    int pix_consumed = 0;
    int labs_checked = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    bit live = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Linearize one 8-bit code following the sRGB transfer curve in Q30.
    function automatic longint unsigned linear_code(input longint unsigned code);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned sq;
        longint unsigned qd;
        if (code * 100000 <= 1031475) begin
            return ((code << 30) * 5) / 16473;
        end
        t  = ((1000 * code + 14025) << 30) / 269025;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = (64'd1 << 30) + 1;
        // Largest w whose truncated fifth power stays at or below t squared.
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            sq  = (mid * mid) >> 30;
            qd  = (sq * sq) >> 30;
            if (((qd * mid) >> 30) <= t2) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return (t2 * lo) >> 30;
    endfunction

    // CIE pivot of a Q30 ratio, result in Q20.
    function automatic longint cie_pivot(input longint unsigned r);
        longint unsigned limit;
        longint unsigned goal;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        limit = (64'd8856 << 30) / 1000000;
        if (r <= limit) begin
            return longint'(((7787 * r) / 1000 + ((64'd16 << 30) / 116)) >> 10);
        end
        goal = r >> 10;
        lo = 0;
        hi = 64'd1 << 26;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if ((((mid * mid) >> 20) * mid) >> 20 <= goal) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return longint'(lo);
    endfunction

    // Bring a Q20 value to 8 fractional bits, ties toward plus infinity.
    function automatic longint to_frac8(input longint v);
        longint x;
        x = v + 2048;
        if (x >= 0) begin
            return x >>> 12;
        end
        return -((-x + 4095) >>> 12);
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_lab lab_of_pixel(input t_pixel p);
        longint unsigned lin [3];
        longint unsigned acc;
        longint unsigned wht;
        longint f [3];
        t_lab res;
        lin[0] = lin_q30[p.red];
        lin[1] = lin_q30[p.green];
        lin[2] = lin_q30[p.blue];
        for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int col = 0; col < 3; col++) begin
                acc += longint'(WEIGHT[row][col]) * lin[col];
            end
            wht = (white_xyz[row] == 0) ? 1 : white_xyz[row];
            f[row] = cie_pivot((acc * 10) / wht);
        end
        res.lightness   = 15'(sat(to_frac8(116 * f[1] - (longint'(16) << 20)), 0, 32767));
        res.green_red   = 16'(sat(to_frac8(500 * (f[0] - f[1])), -32768, 32767));
        res.blue_yellow = 16'(sat(to_frac8(200 * (f[1] - f[2])), -32768, 32767));
        return res;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Sender: offers the next pixel request from the queue, with random gaps.
    always @(negedge i_clk) begin
        if (live && (!pix_ch.valid || pix_taken != pix_consumed)) begin
            pix_consumed = pix_taken;
            if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pixel p;
                p = pending_pix.pop_front();
                pix_ch.valid <= 1'b1;
                pix_ch.red   <= p.red;
                pix_ch.green <= p.green;
                pix_ch.blue  <= p.blue;
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (live) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                lab_ch.ready <= 1'b0;
            end else begin
                lab_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Input side: every accepted pixel request yields its expected L*a*b* value.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            t_pixel p;
            p.red   = pix_ch.red;
            p.green = pix_ch.green;
            p.blue  = pix_ch.blue;
            expected_lab.push_back(lab_of_pixel(p));
            pix_taken++;
        end
    end

    // Output side: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && lab_ch.valid && lab_ch.ready) begin
            t_lab want;
            labs_checked++;
            if (expected_lab.size() == 0) begin
                report("result with no pixel outstanding");
            end else begin
                want = expected_lab.pop_front();
                if (lab_ch.lightness !== want.lightness) begin
                    report($sformatf("lightness %0d, expected %0d",
                                     lab_ch.lightness, want.lightness));
                end
                if (lab_ch.green_red !== want.green_red) begin
                    report($sformatf("green_red %0d, expected %0d",
                                     lab_ch.green_red, want.green_red));
                end
                if (lab_ch.blue_yellow !== want.blue_yellow) begin
                    report($sformatf("blue_yellow %0d, expected %0d",
                                     lab_ch.blue_yellow, want.blue_yellow));
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input longint unsigned value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = WHITE_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx != CFG_UNUSED) begin
            white_xyz[idx] = value & 64'h1FFFF;
        end
    endtask

    task automatic set_white(input longint unsigned wx, input longint unsigned wy,
                             input longint unsigned wz);
        write_reg(CFG_WHITE_X, wx);
        write_reg(CFG_WHITE_Y, wy);
        write_reg(CFG_WHITE_Z, wz);
    endtask

    // Wait until every request has gone through and the pipeline is empty.
    task automatic drain();
        while (pending_pix.size() > 0 || pix_ch.valid || expected_lab.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // Random pixel: mostly uniform, some near the linear segment and the extremes.
    function automatic logic [7:0] rand_code();
        case ($urandom_range(9))
            0: return 8'($urandom_range(12));
            1: return ($urandom_range(1)) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_random(input int count);
        t_pixel p;
        for (int k = 0; k < count; k++) begin
            p.red   = rand_code();
            p.green = rand_code();
            p.blue  = rand_code();
            pending_pix.push_back(p);
        end
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pending_pix.push_back(p);
    endtask

    initial begin
        for (int c = 0; c < 256; c++) begin
            lin_q30[c] = linear_code(c);
        end
        white_xyz[0] = 95047;
        white_xyz[1] = 100000;
        white_xyz[2] = 108883;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_WHITE_X;
        i_cfg_data   = '0;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        lab_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        live    = 1'b1;

        // Directed pixels at the reset white: black, white, primaries, secondaries, grays and the
        // codes on both sides of the transfer curve's linear segment.
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd255);
        queue_pixel(8'd10, 8'd10, 8'd10);
        queue_pixel(8'd11, 8'd11, 8'd11);
        queue_pixel(8'd1, 8'd1, 8'd1);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd1, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd1);
        queue_pixel(8'd170, 8'd85, 8'd170);
        queue_pixel(8'd85, 8'd170, 8'd85);
        drain();

        // Phase: no idling, random pixels at the reset white.
        queue_random(120);
        drain();

        // Phase: low whites, sender idle often.
        set_white(80000, 80000, 80000);
        send_idle_pct = 56;
        queue_random(140);
        drain();

        // Phase: high whites, receiver stalling often.
        set_white(120000, 120000, 120000);
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        queue_random(140);
        drain();

        // Phase: a zero white is taken as one, so the ratios are large and the outputs can saturate.
        set_white(0, 0, 0);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random(120);
        drain();

        // Phase: full-scale register values, then a long receiver hold-off while
        // the sender keeps offering, so the pipeline fills and stalls its input.
        set_white(131071, 131071, 131071);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(160);
        @(posedge i_clk);
        hold_cycles = 400;
        drain();

        // Phase: mixed whites, and a write to an unused index that must change nothing.
        set_white(80000, 120000, 95047);
        write_reg(CFG_UNUSED, 17'd1);
        send_idle_pct  = 56;
        recv_stall_pct = 56;
        queue_random(140);
        drain();

        // Phase: back to D65, both sides idling.
        set_white(95047, 100000, 108883);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random(140);
        drain();

        $display("Converted %0d pixels over eight phases of white settings, zero and full", pix_taken);
        $display("scale included, with sender gaps, receiver stalls and a long output hold-off.");
        if (mismatches == 0) begin
            $display("srgb_to_cielab test passed");
        end else begin
            $display("srgb_to_cielab test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #4000000;
        $display("Timed out with %0d results still expected.", expected_lab.size());
        $display("srgb_to_cielab test failed");
        $finish;
    end

endmodule

// ===== srgb_to_cielab.f =====
rtl/s2lab_pkg.sv
rtl/s2lab_in_if.sv
rtl/s2lab_out_if.sv
rtl/s2lab_div.sv
rtl/s2lab_cbrt.sv
rtl/srgb_to_cielab.sv
test/tb.sv
